// File: sv/fcpu_pkg.sv
// Fly camera pose update: shared types, constants and rounding helpers.
// Used by the top level, the CORDIC unit and the port checker.
package fcpu_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_COUNT        = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_COUNT) ?
                                       CORDIC_ITERATIONS : ATAN_COUNT;
    localparam int CORDIC_CNT_W      = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W        = $clog2(ATAN_COUNT);

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_SENS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED = 4'd1;

    localparam logic [15:0] SENS_RESET  = 16'd12288;
    localparam logic [15:0] SPEED_RESET = 16'd12288;

    localparam logic signed [18:0] YAW_TURN    = 19'sd46080;
    localparam logic signed [18:0] YAW_HALF    = 19'sd23040;
    localparam logic signed [18:0] PITCH_LIMIT = 19'sd11392;

    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [33:0] DEG_90   = 34'sd1509949440;
    localparam logic signed [33:0] DEG_180  = 34'sd3019898880;

    localparam logic signed [31:0] POS_X_RESET = -32'sd32768;
    localparam logic signed [31:0] POS_Y_RESET = 32'sd0;
    localparam logic signed [31:0] POS_Z_RESET = 32'sd65536;
    localparam logic signed [15:0] UNIT_ONE    = 16'sd32767;

    typedef enum logic [0:0] {
        OP_LOOK = 1'b0,
        OP_MOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic               key_forward;
        logic               key_back;
        logic               key_left;
        logic               key_right;
        logic [15:0]        delta_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [15:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } cordic_rsp_t;

    // atan(2^-i) in 2^-24 degree units
    function automatic logic signed [33:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [33:0] r;
        case (idx)
            5'd0:    r = 34'sd754974720;
            5'd1:    r = 34'sd445687602;
            5'd2:    r = 34'sd235489089;
            5'd3:    r = 34'sd119537938;
            5'd4:    r = 34'sd60000934;
            5'd5:    r = 34'sd30029717;
            5'd6:    r = 34'sd15018523;
            5'd7:    r = 34'sd7509720;
            5'd8:    r = 34'sd3754917;
            5'd9:    r = 34'sd1877466;
            5'd10:   r = 34'sd938734;
            5'd11:   r = 34'sd469367;
            5'd12:   r = 34'sd234684;
            5'd13:   r = 34'sd117342;
            5'd14:   r = 34'sd58671;
            5'd15:   r = 34'sd29335;
            5'd16:   r = 34'sd14668;
            5'd17:   r = 34'sd7334;
            5'd18:   r = 34'sd3667;
            5'd19:   r = 34'sd1833;
            5'd20:   r = 34'sd917;
            5'd21:   r = 34'sd458;
            5'd22:   r = 34'sd229;
            5'd23:   r = 34'sd115;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Q.60 product to Q1.15, halves up, saturated
    function automatic logic signed [15:0] rnd45(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + (66'sd1 <<< 44)) >>> 45;
        if (t > 66'sd32767) return 16'sh7fff;
        if (t < -66'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction

    // Q2.30 to Q1.15, halves up, saturated
    function automatic logic signed [15:0] rnd15(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = ($signed({v[32], v}) + 34'sd16384) >>> 15;
        if (t > 34'sd32767) return 16'sh7fff;
        if (t < -34'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction

endpackage

// File: sv/fly_camera_pose_update.sv
// Fly camera pose update: top level with sequencer, shared multiplier and CORDIC.
// Depends on fcpu_pkg and fcpu_cordic.
// Look transaction: mouse gain products and pitch clamp, yaw wrap, the CORDIC loop run for
//   yaw then pitch, the basis products, then the output register.
// Move transaction: step product, four key checks, three position updates per pressed key.
// One transaction at a time; s_ready is high only while the sequencer idles (at the
//   earliest as each result is presented). Synchronous active-low reset restores the
//   default pose and both gains.
module fly_camera_pose_update
    import fcpu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_LOOK   = 10'b0000000010,
        ST_WRAP   = 10'b0000000100,
        ST_CORD   = 10'b0000001000,
        ST_BASIS  = 10'b0000010000,
        ST_MVSTEP = 10'b0000100000,
        ST_MVSEL  = 10'b0001000000,
        ST_MVMUL  = 10'b0010000000,
        ST_MVACC  = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               phase_reg, phase_next;
    logic [1:0]         key_reg, key_next;
    logic [1:0]         comp_reg, comp_next;
    in_item_t           item_reg, item_next;
    logic [15:0]        sens_reg, sens_next;
    logic [15:0]        speed_reg, speed_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic signed [18:0] ny_reg, ny_next;
    logic [31:0]        step_reg, step_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [15:0] basis_reg [9];
    logic signed [15:0] basis_next [9];
    logic signed [31:0] cy_reg, cy_next, sy_reg, sy_next;
    logic signed [31:0] cp_reg, cp_next, sp_reg, sp_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          out_reg, out_next;

    // shared multiplier, product registered
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    cordic_req_t        creq;
    cordic_rsp_t        crsp;

    logic signed [18:0] d_ang, np_sum;
    logic signed [33:0] d_mv, pos_sum;
    logic [3:0]         bidx;
    logic [3:0]         keys;
    logic               key_neg;

    fcpu_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    assign keys    = {item_reg.key_right, item_reg.key_left, item_reg.key_back,
                      item_reg.key_forward};
    assign key_neg = (key_reg == 2'd1) || (key_reg == 2'd2);
    assign bidx    = (key_reg[1] ? 4'd3 : 4'd0) + {2'b00, comp_reg};

    // angle offset from product: Q10.22 -> Q10.7, halves up
    assign d_ang  = 19'((prod_reg + 66'sd16384) >>> 15);
    assign np_sum = {{3{pitch_reg[15]}}, pitch_reg} + d_ang;
    // position delta: Q.45 -> Q16.16, halves up
    assign d_mv   = 34'((prod_reg + (66'sd1 <<< 28)) >>> 29);
    assign pos_sum = key_neg ? ({{2{pos_reg[comp_reg][31]}}, pos_reg[comp_reg]} - d_mv)
                             : ({{2{pos_reg[comp_reg][31]}}, pos_reg[comp_reg]} + d_mv);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOOK: begin
                mul_a = (cnt_reg == 3'd0) ? 33'(item_reg.mouse_dx) : 33'(item_reg.mouse_dy);
                mul_b = {17'd0, sens_reg};
            end
            ST_BASIS: begin
                case (cnt_reg)
                    3'd0: begin mul_a = 33'(cp_reg); mul_b = 33'(cy_reg); end
                    3'd1: begin mul_a = 33'(cp_reg); mul_b = 33'(sy_reg); end
                    3'd2: begin mul_a = 33'(cy_reg); mul_b = 33'(sp_reg); end
                    3'd3: begin mul_a = 33'(sy_reg); mul_b = 33'(sp_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_MVSTEP: begin
                mul_a = {17'd0, item_reg.delta_time};
                mul_b = {17'd0, speed_reg};
            end
            ST_MVMUL: begin
                mul_a = {1'b0, step_reg};
                mul_b = 33'(basis_reg[bidx]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        key_next     = key_reg;
        comp_next    = comp_reg;
        item_next    = item_reg;
        sens_next    = sens_reg;
        speed_next   = speed_reg;
        yaw_next     = yaw_reg;
        pitch_next   = pitch_reg;
        ny_next      = ny_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        basis_next   = basis_reg;
        cy_next      = cy_reg;
        sy_next      = sy_reg;
        cp_next      = cp_reg;
        sp_next      = sp_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        creq.start   = 1'b0;
        creq.angle   = pitch_reg;

        if (cfg_valid) begin
            if (cfg_index == CFG_LOOK_SENS) sens_next = cfg_data;
            else if (cfg_index == CFG_MOVE_SPEED) speed_next = cfg_data;
        end

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = (s_data.operation == OP_MOVE) ? ST_MVSTEP : ST_LOOK;
                end
            end
            ST_LOOK: begin
                // cnt 0 dx*gain issued, 1 yaw sum, 2 pitch clamp
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd1) begin
                    ny_next = {{3{yaw_reg[15]}}, yaw_reg} + d_ang + YAW_HALF;
                end else if (cnt_reg == 3'd2) begin
                    if (np_sum > PITCH_LIMIT) pitch_next = PITCH_LIMIT[15:0];
                    else if (np_sum < -PITCH_LIMIT) pitch_next = 16'(-PITCH_LIMIT);
                    else pitch_next = np_sum[15:0];
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (ny_reg < 19'sd0) begin
                    ny_next = ny_reg + YAW_TURN;
                end else if (ny_reg >= YAW_TURN) begin
                    ny_next = ny_reg - YAW_TURN;
                end else begin
                    yaw_next   = 16'(ny_reg - YAW_HALF);
                    creq.start = 1'b1;
                    creq.angle = 16'(ny_reg - YAW_HALF);
                    phase_next = 1'b0;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                if (crsp.done) begin
                    if (!phase_reg) begin
                        cy_next    = crsp.cos_v;
                        sy_next    = crsp.sin_v;
                        creq.start = 1'b1;
                        creq.angle = pitch_reg;
                        phase_next = 1'b1;
                    end else begin
                        cp_next    = crsp.cos_v;
                        sp_next    = crsp.sin_v;
                        cnt_next   = '0;
                        state_next = ST_BASIS;
                    end
                end
            end
            ST_BASIS: begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    3'd0: begin
                        basis_next[1] = rnd15(33'(sp_reg));
                        basis_next[3] = rnd15(-33'(sy_reg));
                        basis_next[4] = '0;
                        basis_next[5] = rnd15(33'(cy_reg));
                        basis_next[7] = rnd15(33'(cp_reg));
                    end
                    3'd1: basis_next[0] = rnd45(prod_reg);
                    3'd2: basis_next[2] = rnd45(prod_reg);
                    3'd3: basis_next[6] = rnd45(-prod_reg);
                    3'd4: begin
                        basis_next[8] = rnd45(-prod_reg);
                        state_next    = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_MVSTEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd1) begin
                    step_next  = prod_reg[31:0];
                    key_next   = '0;
                    state_next = ST_MVSEL;
                end
            end
            ST_MVSEL: begin
                comp_next = '0;
                if (keys[key_reg]) state_next = ST_MVMUL;
                else if (key_reg == 2'd3) state_next = ST_OUT;
                else key_next = key_reg + 1'b1;
            end
            ST_MVMUL: state_next = ST_MVACC;
            ST_MVACC: begin
                if (pos_sum > 34'sd2147483647) pos_next[comp_reg] = 32'sh7fffffff;
                else if (pos_sum < -34'sd2147483648) pos_next[comp_reg] = 32'sh80000000;
                else pos_next[comp_reg] = pos_sum[31:0];
                if (comp_reg == 2'd2) begin
                    comp_next = '0;
                    if (key_reg == 2'd3) begin
                        state_next = ST_OUT;
                    end else begin
                        key_next   = key_reg + 1'b1;
                        state_next = ST_MVSEL;
                    end
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_MVMUL;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next.pos_x   = pos_reg[0];
                    out_next.pos_y   = pos_reg[1];
                    out_next.pos_z   = pos_reg[2];
                    out_next.front_x = basis_reg[0];
                    out_next.front_y = basis_reg[1];
                    out_next.front_z = basis_reg[2];
                    out_next.right_x = basis_reg[3];
                    out_next.right_y = basis_reg[4];
                    out_next.right_z = basis_reg[5];
                    out_next.up_x    = basis_reg[6];
                    out_next.up_y    = basis_reg[7];
                    out_next.up_z    = basis_reg[8];
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            phase_reg   <= 1'b0;
            key_reg     <= '0;
            comp_reg    <= '0;
            sens_reg    <= SENS_RESET;
            speed_reg   <= SPEED_RESET;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            pos_reg[0]  <= POS_X_RESET;
            pos_reg[1]  <= POS_Y_RESET;
            pos_reg[2]  <= POS_Z_RESET;
            basis_reg   <= '{UNIT_ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, UNIT_ONE,
                             16'sd0, UNIT_ONE, 16'sd0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            key_reg     <= key_next;
            comp_reg    <= comp_next;
            sens_reg    <= sens_next;
            speed_reg   <= speed_next;
            yaw_reg     <= yaw_next;
            pitch_reg   <= pitch_next;
            pos_reg     <= pos_next;
            basis_reg   <= basis_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg <= item_next;
        ny_reg   <= ny_next;
        step_reg <= step_next;
        cy_reg   <= cy_next;
        sy_reg   <= sy_next;
        cp_reg   <= cp_next;
        sp_reg   <= sp_next;
        out_reg  <= out_next;
        prod_reg <= mul_a * mul_b;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

endmodule

// File: sv/fcpu_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on fcpu_pkg for the arctangent table and request/response types.
module fcpu_cordic
    import fcpu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic [CORDIC_CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [33:0]      x_reg, x_next;
    logic signed [33:0]      y_reg, y_next;
    logic signed [33:0]      z_reg, z_next;
    logic signed [33:0]      z_init;
    logic signed [33:0]      x_sh, y_sh, atan_i;
    logic signed [33:0]      x_out, y_out;

    assign x_sh   = x_reg >>> cnt_reg;
    assign y_sh   = y_reg >>> cnt_reg;
    assign atan_i = atan_val(ATAN_IDX_W'(cnt_reg));
    assign z_init = {req.angle[15], req.angle, 17'd0};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = INV_GAIN;
            y_next    = '0;
            if (z_init > DEG_90) begin
                z_next   = z_init - DEG_180;
                neg_next = 1'b1;
            end else if (z_init < -DEG_90) begin
                z_next   = z_init + DEG_180;
                neg_next = 1'b1;
            end else begin
                z_next   = z_init;
                neg_next = 1'b0;
            end
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_i;
            end else begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_i;
            end
            if (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign x_out     = neg_reg ? -x_reg : x_reg;
    assign y_out     = neg_reg ? -y_reg : y_reg;
    assign rsp.done  = done_reg;
    assign rsp.cos_v = x_out[31:0];
    assign rsp.sin_v = y_out[31:0];

endmodule

// File: sv/fcpu_checker.sv
// Port-level checker for the fly camera pose update, bound to the top level.
// Depends on fcpu_pkg for the transaction types.
module fcpu_port_props
    import fcpu_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a result waiting is held
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // block is busy right after taking a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an input transaction");

    // right vector never leaves the horizontal plane
    a_right_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.right_y == 16'sd0)
        else $error("right_y nonzero");

    // a new result only comes out of a busy sequencer
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work");

endmodule

bind fly_camera_pose_update fcpu_port_props u_fcpu_port_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: sim/fcpu_checker.sv
// Port checker for the fly camera pose unit: watches all three channels,
// predicts each pose and compares it. Depends on fcpu_pkg.
`timescale 1ns / 100ps
module fcpu_checker
    import fcpu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   mismatches,
    output int                   poses_pending
);

    localparam longint ATAN_DEG [24] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115};

    logic [15:0] gain_look, gain_move;
    longint      yaw_q7, pitch_q7;
    longint      pos [3];
    longint      basis [9];   // front, right, up
    out_item_t   pose_q [$];

    assign poses_pending = pose_q.size();

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = ang * 131072;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 90 * 64'sd16777216) begin
            z -= 180 * 64'sd16777216;
            flip = 1;
        end else if (z < -90 * 64'sd16777216) begin
            z += 180 * 64'sd16777216;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_DEG[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_DEG[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    task automatic step_pos(input longint stp, input int base, input int sgn);
        longint d;
        for (int k = 0; k < 3; k++) begin
            d = rnd_shift(stp * basis[base + k], 29);
            pos[k] = clip(pos[k] + sgn * d, -64'sd2147483648, 64'sd2147483647);
        end
    endtask

    task automatic apply_item(input in_item_t it);
        longint cy, sy, cp, sp, ny, np, stp;
        out_item_t p;
        if (it.operation == OP_LOOK) begin
            ny = yaw_q7 + rnd_shift(longint'(it.mouse_dx) * longint'(gain_look), 15) + 23040;
            np = pitch_q7 + rnd_shift(longint'(it.mouse_dy) * longint'(gain_look), 15);
            yaw_q7   = ((ny % 46080) + 46080) % 46080 - 23040;
            pitch_q7 = clip(np, -11392, 11392);
            sin_cos(yaw_q7, cy, sy);
            sin_cos(pitch_q7, cp, sp);
            basis[0] = clip(rnd_shift(cp * cy, 45), -32768, 32767);
            basis[1] = clip(rnd_shift(sp, 15), -32768, 32767);
            basis[2] = clip(rnd_shift(cp * sy, 45), -32768, 32767);
            basis[3] = clip(rnd_shift(-sy, 15), -32768, 32767);
            basis[4] = 0;
            basis[5] = clip(rnd_shift(cy, 15), -32768, 32767);
            basis[6] = clip(rnd_shift(-(cy * sp), 45), -32768, 32767);
            basis[7] = clip(rnd_shift(cp, 15), -32768, 32767);
            basis[8] = clip(rnd_shift(-(sy * sp), 45), -32768, 32767);
        end else begin
            stp = longint'(it.delta_time) * longint'(gain_move);
            if (it.key_forward) step_pos(stp, 0, 1);
            if (it.key_back)    step_pos(stp, 0, -1);
            if (it.key_left)    step_pos(stp, 3, -1);
            if (it.key_right)   step_pos(stp, 3, 1);
        end
        p.pos_x   = pos[0][31:0];
        p.pos_y   = pos[1][31:0];
        p.pos_z   = pos[2][31:0];
        p.front_x = basis[0][15:0];
        p.front_y = basis[1][15:0];
        p.front_z = basis[2][15:0];
        p.right_x = basis[3][15:0];
        p.right_y = basis[4][15:0];
        p.right_z = basis[5][15:0];
        p.up_x    = basis[6][15:0];
        p.up_y    = basis[7][15:0];
        p.up_z    = basis[8][15:0];
        pose_q.push_back(p);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_look <= SENS_RESET;
            gain_move <= SPEED_RESET;
            yaw_q7 = 0;
            pitch_q7 = 0;
            pos = '{-32768, 0, 65536};
            basis = '{32767, 0, 0, 0, 0, 32767, 0, 32767, 0};
            pose_q.delete();
            mismatches <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_LOOK_SENS) gain_look <= cfg_data;
                else if (cfg_index == CFG_MOVE_SPEED) gain_move <= cfg_data;
            end
            if (s_valid && s_ready) apply_item(s_data);
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    if (mismatches < 10) $display("unexpected pose %p", m_data);
                    mismatches <= mismatches + 1;
                end else if (pose_q[0] !== m_data) begin
                    if (mismatches < 10)
                        $display("pose mismatch\n  exp %p\n  got %p", pose_q[0], m_data);
                    mismatches <= mismatches + 1;
                    void'(pose_q.pop_front());
                end else begin
                    void'(pose_q.pop_front());
                end
            end
        end
    end

endmodule

// File: sim/tb.sv
// Testbench top for fly_camera_pose_update: directed and random look/move
// traffic over several gain settings and idling phases. Depends on fcpu_pkg, fcpu_checker.
`timescale 1ns / 100ps
module tb;
    import fcpu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;   // no such register
    localparam int CYCLE_LIMIT = 400000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    int                   mismatches;
    int                   poses_pending;
    int                   send_idle_pct = 0;    // chance a cycle is left idle
    int                   recv_stall_pct = 0;   // chance m_ready drops
    int                   cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    fly_camera_pose_update u_dut (.*);

    fcpu_checker u_chk (.*);

    // receiver back-pressure
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fly_camera_pose_update verification failed");
            $finish;
        end
    end

    // one input transaction; valid held from one item to the next when no gap
    task automatic send_pose_item(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until every pose is back, then let the pipe settle
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (poses_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t look_item(input int dx, input int dy);
        in_item_t it;
        it = in_item_t'(53'({$urandom, $urandom}));   // keys and time must be ignored
        it.operation = OP_LOOK;
        it.mouse_dx  = dx[15:0];
        it.mouse_dy  = dy[15:0];
        return it;
    endfunction

    function automatic in_item_t move_item(input logic [3:0] keys, input logic [15:0] dt);
        in_item_t it;
        it = in_item_t'(53'({$urandom, $urandom}));   // mouse fields must be ignored
        it.operation = OP_MOVE;
        {it.key_forward, it.key_back, it.key_left, it.key_right} = keys;
        it.delta_time = dt;
        return it;
    endfunction

    function automatic in_item_t random_item();
        int dx, dy;
        if ($urandom_range(1)) return move_item(4'($urandom), 16'($urandom));
        // mostly modest mouse moves, sometimes full-range offsets
        dx = $urandom_range(3) == 0 ? int'($urandom) : $urandom_range(8000) - 4000;
        dy = $urandom_range(3) == 0 ? int'($urandom) : $urandom_range(8000) - 4000;
        return look_item(dx, dy);
    endfunction

    initial begin
        int idle_sets [4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{25, 25}};
        logic [15:0] sens_sets  [4] = '{16'd65535, 16'd0, 16'd3000, 16'd16384};
        logic [15:0] speed_sets [4] = '{16'd65535, 16'd0, 16'd40000, 16'd12288};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default gains, pitch clamp, yaw past +-90, every key alone and together
        send_pose_item(move_item(4'b1000, 16'hFFFF));
        send_pose_item(look_item(32767, 32767));
        send_pose_item(look_item(-32768, -32768));
        send_pose_item(look_item(0, 0));
        send_pose_item(look_item(16000, 2000));
        send_pose_item(look_item(16000, -6000));
        send_pose_item(look_item(-30000, 0));
        send_pose_item(move_item(4'b1000, 16'd30000));
        send_pose_item(move_item(4'b0100, 16'd30000));
        send_pose_item(move_item(4'b0010, 16'hFFFF));
        send_pose_item(move_item(4'b0001, 16'hFFFF));
        send_pose_item(move_item(4'b1111, 16'hFFFF));
        send_pose_item(move_item(4'b1100, 16'd1));
        send_pose_item(move_item(4'b0000, 16'hFFFF));
        send_pose_item(move_item(4'b1010, 16'd0));
        send_pose_item(look_item(1, -1));
        drain();

        // unknown register index must be dropped
        write_gain(CFG_UNUSED, 16'd1);
        send_pose_item(look_item(4000, 4000));
        send_pose_item(move_item(4'b1001, 16'd5000));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_gain(CFG_LOOK_SENS, sens_sets[ph]);
            write_gain(CFG_MOVE_SPEED, speed_sets[ph]);
            send_idle_pct  = idle_sets[ph][0];
            recv_stall_pct = idle_sets[ph][1];
            for (int n = 0; n < 160; n++) send_pose_item(random_item());
            drain();
        end

        if (mismatches == 0 && poses_pending == 0) begin
            $display("fly_camera_pose_update verification clean");
        end else begin
            $display("fly_camera_pose_update verification failed");
        end
        $finish;
    end

endmodule
